// ===== sv/pgd_pkg.sv =====
// Package with the shared types, constants and tables of the geodesic distance block.
package pgd_pkg;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 20;
    localparam int CNT_W   = 5;
    localparam int IDX_W   = 6;

    localparam logic [4:0]  MAX_SPHERES = 5'd16;
    localparam logic [17:0] PI_Q16      = 18'd205887;
    localparam logic [23:0] PI2_Q20     = 24'd10349030;
    localparam logic [39:0] ANG_MAX     = 40'hFF_FFFF_FFFF;
    localparam logic [36:0] SQ_MAX      = {37{1'b1}};
    localparam logic [30:0] UNIT_NORM   = 31'h4000_0000;

    localparam logic [IDX_W-1:0] SQRT_STEPS  = 6'd32;
    localparam logic [IDX_W-1:0] DIVC_STEPS  = 6'd17;
    localparam logic [IDX_W-1:0] CORD_STEPS  = 6'd24;
    localparam logic [IDX_W-1:0] DIVD_STEPS  = 6'd60;

    localparam logic [1:0] REG_NORM_FIRST  = 2'd0;
    localparam logic [1:0] REG_NORM_SECOND = 2'd1;
    localparam logic [1:0] REG_STANDARDIZE = 2'd2;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_ACC,
        OP_SQ1_LD,
        OP_SQ2_LD,
        OP_SQS_LD,
        OP_SQD_LD,
        OP_SQRT,
        OP_SAVE_R1,
        OP_SAVE_R2,
        OP_DEN,
        OP_DIVC_LD,
        OP_DIVD_LD,
        OP_DIV_STEP,
        OP_COS,
        OP_ASQ,
        OP_COR_LD,
        OP_COR,
        OP_ANG,
        OP_ANGSQ,
        OP_CLOSE,
        OP_DIVISOR,
        OP_RESULT
    } pgd_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACC,
        ST_SQ1_LD,
        ST_SQ1,
        ST_R1,
        ST_SQ2_LD,
        ST_SQ2,
        ST_R2,
        ST_DEN,
        ST_DIVC_LD,
        ST_DIVC,
        ST_COS,
        ST_ASQ,
        ST_SQS_LD,
        ST_SQS,
        ST_COR_LD,
        ST_COR,
        ST_ANG,
        ST_ANGSQ,
        ST_CLOSE,
        ST_DIVISOR,
        ST_DIVD_LD,
        ST_DIVD,
        ST_SQD_LD,
        ST_SQD,
        ST_RESULT
    } pgd_state_t;

    typedef struct packed {
        pgd_op_t          op;
        logic [IDX_W-1:0] idx;
    } pgd_cmd_t;

    typedef struct packed {
        logic blk_end;
        logic pt_end;
    } pgd_status_t;

    function automatic logic [23:0] atan_q24(input logic [4:0] i);
        logic [23:0] v;
        case (i)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/pgd_if.sv =====
// Request channel interfaces for coordinate pairs and distance results.
interface pgd_in_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] first_coord;
    logic signed [15:0] second_coord;
    logic        sphere_end;
    logic        point_end;

    modport source (output valid, first_coord, second_coord, sphere_end, point_end,
                    input ready);
    modport sink   (input valid, first_coord, second_coord, sphere_end, point_end,
                    output ready);
endinterface

interface pgd_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] distance;
    logic        clamped;
    logic        zero_norm;
    logic [4:0]  spheres_seen;

    modport source (output valid, distance, clamped, zero_norm, spheres_seen,
                    input ready);
    modport sink   (input valid, distance, clamped, zero_norm, spheres_seen,
                    output ready);
endinterface

// ===== sv/polysphere_geodesic_distance.sv =====
// Top level of the product-of-spheres geodesic distance block.
//
// Coordinate pairs arrive on in_ch, one request per coordinate, with
// sphere_end marking the last coordinate of a sphere block and point_end the
// last coordinate of a point pair. One result request leaves on out_ch for
// each point_end. The three configuration registers are written over the
// cfg_we / cfg_index / cfg_data port, by the user only while the block is
// idle; the block itself does not enforce this. The block works on one
// coordinate at a time under a sequencer. A plain coordinate is accepted,
// then accumulated. A block end runs the shared bit-serial square root
// unit (three roots of 32 steps), the 17-step cosine divider and the
// 24-step CORDIC arccosine; a point end also runs the 60-step distance
// divider and the final root. The result sits in an output register, so
// the next coordinate is taken while a result still waits; the sequencer
// holds only when a new result is ready and the receiver stalls the old one.
// Reset, asynchronous and active low, clears all sums, flags and counters,
// drops any waiting result and restores the register defaults
// (no normalization, standardize on).
module polysphere_geodesic_distance (
    input  logic            clk,
    input  logic            rst_n,
    pgd_in_if.sink          in_ch,
    pgd_out_if.source       out_ch,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic            cfg_data
);
    import pgd_pkg::*;

    pgd_cmd_t    cmd;
    pgd_status_t status;
    logic        in_fire;

    // A request is taken only while the sequencer waits for a coordinate.
    assign in_fire = in_ch.valid && in_ch.ready;

    pgd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pgd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_fire      (in_fire),
        .first_coord  (in_ch.first_coord),
        .second_coord (in_ch.second_coord),
        .sphere_end   (in_ch.sphere_end),
        .point_end    (in_ch.point_end),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .distance     (out_ch.distance),
        .clamped      (out_ch.clamped),
        .zero_norm    (out_ch.zero_norm),
        .spheres_seen (out_ch.spheres_seen)
    );

`ifndef ASSERT_OFF
    // After taking a coordinate the block is busy accumulating it.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ch.ready)
        else $error("coordinate accepted while previous one still in work");

    // Every result closes at least one sphere block.
    a_spheres_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.spheres_seen != 5'd0))
        else $error("result with no sphere block");

    // The sphere count saturates at its limit.
    a_spheres_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.spheres_seen <= MAX_SPHERES))
        else $error("sphere count above limit");
`endif

endmodule

// ===== sv/pgd_ctrl.sv =====
// Sequencer that steps the datapath through accumulation, block close and result.
module pgd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  pgd_pkg::pgd_status_t status,
    output pgd_pkg::pgd_cmd_t   cmd
);
    import pgd_pkg::*;

    pgd_state_t       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             ovalid_reg, ovalid_next;
    logic             last;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg + 1'b1;
        ovalid_next = ovalid_reg && !out_ready;
        cmd.op      = OP_IDLE;
        cmd.idx     = cnt_reg;
        last        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.op = OP_ACC;
                state_next = (status.blk_end || status.pt_end) ? ST_SQ1_LD : ST_IDLE;
            end
            ST_SQ1_LD:
            begin
                cmd.op = OP_SQ1_LD;
                cnt_next = '0;
                state_next = ST_SQ1;
            end
            ST_SQ1:
            begin
                cmd.op = OP_SQRT;
                last = (cnt_reg == SQRT_STEPS - 1'b1);
                if (last)
                    state_next = ST_R1;
            end
            ST_R1:
            begin
                cmd.op = OP_SAVE_R1;
                state_next = ST_SQ2_LD;
            end
            ST_SQ2_LD:
            begin
                cmd.op = OP_SQ2_LD;
                cnt_next = '0;
                state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                cmd.op = OP_SQRT;
                last = (cnt_reg == SQRT_STEPS - 1'b1);
                if (last)
                    state_next = ST_R2;
            end
            ST_R2:
            begin
                cmd.op = OP_SAVE_R2;
                state_next = ST_DEN;
            end
            ST_DEN:
            begin
                cmd.op = OP_DEN;
                state_next = ST_DIVC_LD;
            end
            ST_DIVC_LD:
            begin
                cmd.op = OP_DIVC_LD;
                cnt_next = '0;
                state_next = ST_DIVC;
            end
            ST_DIVC:
            begin
                cmd.op = OP_DIV_STEP;
                last = (cnt_reg == DIVC_STEPS - 1'b1);
                if (last)
                    state_next = ST_COS;
            end
            ST_COS:
            begin
                cmd.op = OP_COS;
                state_next = ST_ASQ;
            end
            ST_ASQ:
            begin
                cmd.op = OP_ASQ;
                state_next = ST_SQS_LD;
            end
            ST_SQS_LD:
            begin
                cmd.op = OP_SQS_LD;
                cnt_next = '0;
                state_next = ST_SQS;
            end
            ST_SQS:
            begin
                cmd.op = OP_SQRT;
                last = (cnt_reg == SQRT_STEPS - 1'b1);
                if (last)
                    state_next = ST_COR_LD;
            end
            ST_COR_LD:
            begin
                cmd.op = OP_COR_LD;
                cnt_next = '0;
                state_next = ST_COR;
            end
            ST_COR:
            begin
                cmd.op = OP_COR;
                last = (cnt_reg == CORD_STEPS - 1'b1);
                if (last)
                    state_next = ST_ANG;
            end
            ST_ANG:
            begin
                cmd.op = OP_ANG;
                state_next = ST_ANGSQ;
            end
            ST_ANGSQ:
            begin
                cmd.op = OP_ANGSQ;
                state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                cmd.op = OP_CLOSE;
                state_next = status.pt_end ? ST_DIVISOR : ST_IDLE;
            end
            ST_DIVISOR:
            begin
                cmd.op = OP_DIVISOR;
                state_next = ST_DIVD_LD;
            end
            ST_DIVD_LD:
            begin
                cmd.op = OP_DIVD_LD;
                cnt_next = '0;
                state_next = ST_DIVD;
            end
            ST_DIVD:
            begin
                cmd.op = OP_DIV_STEP;
                last = (cnt_reg == DIVD_STEPS - 1'b1);
                if (last)
                    state_next = ST_SQD_LD;
            end
            ST_SQD_LD:
            begin
                cmd.op = OP_SQD_LD;
                cnt_next = '0;
                state_next = ST_SQD;
            end
            ST_SQD:
            begin
                cmd.op = OP_SQRT;
                last = (cnt_reg == SQRT_STEPS - 1'b1);
                if (last)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.op = OP_RESULT;
                    ovalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/pgd_dp.sv =====
// Datapath with accumulators, shared square root, divider, CORDIC and result registers.
module pgd_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  pgd_pkg::pgd_cmd_t cmd,
    output pgd_pkg::pgd_status_t status,
    input  logic              in_fire,
    input  logic signed [15:0] first_coord,
    input  logic signed [15:0] second_coord,
    input  logic              sphere_end,
    input  logic              point_end,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic              cfg_data,
    output logic [19:0]       distance,
    output logic              clamped,
    output logic              zero_norm,
    output logic [4:0]        spheres_seen
);
    import pgd_pkg::*;

    localparam logic signed [38:0] DOT_MAX = 39'sd137438953471;
    localparam logic signed [38:0] DOT_MIN = -39'sd137438953472;

    logic nf_reg, ns_reg, std_reg;
    logic signed [15:0] x_reg, y_reg;
    logic se_reg, pe_reg;
    logic signed [37:0] dot_reg;
    logic [36:0] fss_reg, sss_reg;
    logic [39:0] asum_reg;
    logic [4:0]  cnt_reg;
    logic        clamp_reg, zn_reg;
    logic [63:0] sq_v_reg, sq_r_reg, sq_b_reg;
    logic [31:0] r1_reg, r2_reg;
    logic [63:0] den_reg, rem_reg, num_reg, q_reg;
    logic [16:0] a_reg;
    logic        neg_reg;
    logic [33:0] asq_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [27:0] cz_reg;
    logic [17:0] ang_reg;
    logic [35:0] angsq_reg;
    logic [19:0] dist_reg;
    logic        oclamp_reg, ozn_reg;
    logic [4:0]  ocnt_reg;

    logic signed [31:0] pxy, pxx, pyy;
    logic signed [38:0] dot_wide;
    logic signed [37:0] dot_next;
    logic [37:0] fss_wide, sss_wide;
    logic [36:0] nx, ny;
    logic [64:0] trial;
    logic        trial_ok;
    logic [64:0] rem2;
    logic        div_ok;
    logic [37:0] mag;
    logic        den_zero, clamp_hit;
    logic signed [33:0] dx, dy;
    logic signed [27:0] at;
    logic [27:0] zc, rnd;
    logic [19:0] angr;
    logic [17:0] angc, ang_fin;
    logic [40:0] asum_wide;
    logic [63:0] sqd_in;

    assign status.blk_end = se_reg;
    assign status.pt_end  = pe_reg;

    assign distance     = dist_reg;
    assign clamped      = oclamp_reg;
    assign zero_norm    = ozn_reg;
    assign spheres_seen = ocnt_reg;

    always_comb
    begin
        pxy = x_reg * y_reg;
        pxx = x_reg * x_reg;
        pyy = y_reg * y_reg;
        dot_wide = 39'(dot_reg) + 39'(pxy);
        if (dot_wide > DOT_MAX)
            dot_next = 38'(DOT_MAX);
        else if (dot_wide < DOT_MIN)
            dot_next = 38'(DOT_MIN);
        else
            dot_next = 38'(dot_wide);
        fss_wide = {1'b0, fss_reg} + {6'b0, 32'(pxx)};
        sss_wide = {1'b0, sss_reg} + {6'b0, 32'(pyy)};
        nx = nf_reg ? fss_reg : {6'b0, UNIT_NORM};
        ny = ns_reg ? sss_reg : {6'b0, UNIT_NORM};

        trial    = {1'b0, sq_r_reg} + {1'b0, sq_b_reg};
        trial_ok = ({1'b0, sq_v_reg} >= trial);

        rem2   = {rem_reg, num_reg[63]};
        div_ok = (rem2 >= {1'b0, den_reg});

        mag       = 38'(dot_reg[37] ? -dot_reg : dot_reg);
        den_zero  = (den_reg == 64'd0);
        clamp_hit = ({mag, 26'b0} > den_reg);

        dx = cy_reg >>> cmd.idx[4:0];
        dy = cx_reg >>> cmd.idx[4:0];
        at = 28'(atan_q24(cmd.idx[4:0]));

        zc   = cz_reg[27] ? 28'd0 : 28'(cz_reg);
        rnd  = zc + 28'd128;
        angr = rnd[27:8];
        angc = (angr > 20'(PI_Q16)) ? PI_Q16 : angr[17:0];
        ang_fin = neg_reg ? (PI_Q16 - angc) : angc;

        asum_wide = {1'b0, asum_reg} + {5'b0, angsq_reg};
        sqd_in = (std_reg && (cnt_reg != 5'd0)) ? q_reg : {24'b0, asum_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nf_reg    <= 1'b0;
            ns_reg    <= 1'b0;
            std_reg   <= 1'b1;
            dot_reg   <= '0;
            fss_reg   <= '0;
            sss_reg   <= '0;
            asum_reg  <= '0;
            cnt_reg   <= '0;
            clamp_reg <= 1'b0;
            zn_reg    <= 1'b0;
            se_reg    <= 1'b0;
            pe_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NORM_FIRST:  nf_reg  <= cfg_data;
                    REG_NORM_SECOND: ns_reg  <= cfg_data;
                    REG_STANDARDIZE: std_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_fire)
            begin
                se_reg <= sphere_end;
                pe_reg <= point_end;
            end
            case (cmd.op)
                OP_ACC:
                begin
                    dot_reg <= dot_next;
                    fss_reg <= fss_wide[37] ? SQ_MAX : fss_wide[36:0];
                    sss_reg <= sss_wide[37] ? SQ_MAX : sss_wide[36:0];
                end
                OP_COS:
                begin
                    if (den_zero)
                        zn_reg <= 1'b1;
                    else if (clamp_hit)
                        clamp_reg <= 1'b1;
                end
                OP_CLOSE:
                begin
                    asum_reg <= (asum_wide > {1'b0, ANG_MAX}) ? ANG_MAX : asum_wide[39:0];
                    if (cnt_reg < MAX_SPHERES)
                        cnt_reg <= cnt_reg + 5'd1;
                    dot_reg <= '0;
                    fss_reg <= '0;
                    sss_reg <= '0;
                end
                OP_RESULT:
                begin
                    asum_reg  <= '0;
                    cnt_reg   <= '0;
                    clamp_reg <= 1'b0;
                    zn_reg    <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg <= first_coord;
            y_reg <= second_coord;
        end
        case (cmd.op)
            OP_SQ1_LD, OP_SQ2_LD, OP_SQS_LD, OP_SQD_LD:
            begin
                sq_r_reg <= '0;
                sq_b_reg <= 64'h4000_0000_0000_0000;
                case (cmd.op)
                    OP_SQ1_LD: sq_v_reg <= {1'b0, nx, 26'b0};
                    OP_SQ2_LD: sq_v_reg <= {1'b0, ny, 26'b0};
                    OP_SQS_LD: sq_v_reg <= 64'(34'h1_0000_0000 - asq_reg);
                    default:   sq_v_reg <= sqd_in;
                endcase
            end
            OP_SQRT:
            begin
                if (trial_ok)
                begin
                    sq_v_reg <= 64'(65'({1'b0, sq_v_reg}) - trial);
                    sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
                end
                else
                    sq_r_reg <= sq_r_reg >> 1;
                sq_b_reg <= sq_b_reg >> 2;
            end
            OP_SAVE_R1: r1_reg <= sq_r_reg[31:0];
            OP_SAVE_R2: r2_reg <= sq_r_reg[31:0];
            OP_DEN:     den_reg <= r1_reg * r2_reg;
            OP_DIVC_LD:
            begin
                rem_reg <= {1'b0, mag, 25'b0};
                num_reg <= '0;
                q_reg   <= '0;
            end
            OP_DIVISOR: den_reg <= {40'b0, PI2_Q20} * {59'b0, cnt_reg};
            OP_DIVD_LD:
            begin
                rem_reg <= '0;
                num_reg <= {asum_reg, 24'b0};
                q_reg   <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= div_ok ? 64'(rem2 - {1'b0, den_reg}) : rem2[63:0];
                num_reg <= num_reg << 1;
                q_reg   <= {q_reg[62:0], div_ok};
            end
            OP_COS:
            begin
                neg_reg <= dot_reg[37] && !den_zero;
                if (den_zero)
                    a_reg <= '0;
                else if (clamp_hit)
                    a_reg <= 17'h10000;
                else
                    a_reg <= q_reg[16:0];
            end
            OP_ASQ: asq_reg <= a_reg * a_reg;
            OP_COR_LD:
            begin
                cx_reg <= 34'({a_reg, 12'b0});
                cy_reg <= 34'({sq_r_reg[16:0], 12'b0});
                cz_reg <= '0;
            end
            OP_COR:
            begin
                if (!cy_reg[33])
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + at;
                end
                else
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - at;
                end
            end
            OP_ANG:   ang_reg <= ang_fin;
            OP_ANGSQ: angsq_reg <= ang_reg * ang_reg;
            OP_RESULT:
            begin
                dist_reg   <= (sq_r_reg > 64'd1048575) ? 20'hFFFFF : sq_r_reg[19:0];
                oclamp_reg <= clamp_reg;
                ozn_reg    <= zn_reg;
                ocnt_reg   <= cnt_reg;
            end
            default: ;
        endcase
    end

endmodule
